FILE: sv/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg: shared types and constants of the first-fit page allocator
// Table geometry, item layout, status codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int PAGES      = 1024;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int IDX_W      = $clog2(PAGES);
	localparam int RUN_W      = $clog2(PAGES + 1);

	localparam int ADDR_W = 48;
	localparam int CNT_W  = 11;
	localparam int ST_W   = 2;
	localparam int CMP_W  = (RUN_W > CNT_W) ? RUN_W : CNT_W;

	localparam int IN_W    = ((CNT_W + ADDR_W + 7) / 8) * 8;
	localparam int OUT_W   = ((ST_W + ADDR_W + 7) / 8) * 8;
	localparam int OUT_PAD = OUT_W - ST_W - ADDR_W;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] FLAGS_FREE = 2'b00;
	localparam logic [1:0] FLAGS_USED = 2'b01;
	localparam logic [1:0] FLAGS_LAST = 2'b11;
	localparam int         LAST_BIT   = 1;

	typedef struct packed {
		logic load;
		logic check;
		logic scan_alloc;
		logic scan_free;
		logic mark_step;
		logic clr_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic chk_fail;
		logic is_free;
		logic hit;
		logic scan_last;
		logic free_stop;
		logic mark_done;
		logic out_free;
	} sts_t;

endpackage

FILE: sv/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl: allocator sequencer
// Walks the table clear after reset, then runs check, scan, mark and result
// phases for one item at a time.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  ffpa_pkg::sts_t sts,
	output ffpa_pkg::cmd_t cmd
);
	import ffpa_pkg::*;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_ASCAN = 3'd3;
	localparam logic [2:0] S_AMARK = 3'd4;
	localparam logic [2:0] S_FSCAN = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.scan_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = S_CHK;
				end
			end
			S_CHK: begin
				cmd.check = 1'b1;
				if (sts.chk_fail) begin
					state_nxt = S_DONE;
				end else if (sts.is_free) begin
					state_nxt = S_FSCAN;
				end else begin
					state_nxt = S_ASCAN;
				end
			end
			S_ASCAN: begin
				cmd.scan_alloc = 1'b1;
				if (sts.hit) begin
					state_nxt = S_AMARK;
				end else if (sts.scan_last) begin
					state_nxt = S_DONE;
				end
			end
			S_AMARK: begin
				cmd.mark_step = 1'b1;
				if (sts.mark_done) begin
					state_nxt = S_DONE;
				end
			end
			S_FSCAN: begin
				cmd.scan_free = 1'b1;
				if (sts.free_stop) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: sv/ffpa_dp.sv
// ----------------------------------------------------------------------------
// ffpa_dp: allocator datapath
// Page flag memory, scan counters, run tracking, range check, base register
// and the output register.
// ----------------------------------------------------------------------------
module ffpa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [ffpa_pkg::ADDR_W-1:0]    cfg_data,
	input  logic [ffpa_pkg::IN_W-1:0]      s_tdata,
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ffpa_pkg::OUT_W-1:0]     m_tdata,
	input  ffpa_pkg::cmd_t                 cmd,
	output ffpa_pkg::sts_t                 sts
);
	import ffpa_pkg::*;

	logic [1:0] mem [PAGES];

	logic [ADDR_W-1:0] base_q;
	logic              kind_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] addr_q;

	logic [IDX_W-1:0]  scan_q;
	logic [RUN_W-1:0]  run_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  end_q;
	logic [ST_W-1:0]   status_q;
	logic [1:0]        rdata_q;

	logic              m_valid_q;
	logic [ST_W-1:0]   m_status_q;
	logic [ADDR_W-1:0] m_addr_q;

	logic [ADDR_W:0]          diff;
	logic [ADDR_W-1:0]        off;
	logic                     below_base;
	logic                     beyond_end;
	logic [IDX_W-1:0]         start_idx;
	logic                     cnt_bad;
	logic                     entry_free;
	logic [IDX_W-1:0]         scan_inc;
	logic [IDX_W-1:0]         hit_first;

	logic                     we;
	logic [IDX_W-1:0]         waddr;
	logic [1:0]               wdata;
	logic [IDX_W-1:0]         raddr;

	assign diff       = {1'b0, addr_q} - {1'b0, base_q};
	assign off        = diff[ADDR_W-1:0];
	assign below_base = diff[ADDR_W];
	assign beyond_end = off[ADDR_W-1:PAGE_SHIFT] >= (ADDR_W-PAGE_SHIFT)'(PAGES);
	assign start_idx  = (kind_q == KIND_FREE) ? off[PAGE_SHIFT +: IDX_W] : '0;
	assign cnt_bad    = (count_q == '0) || (CMP_W'(count_q) > CMP_W'(PAGES));

	assign entry_free = (rdata_q == FLAGS_FREE);
	assign scan_inc   = scan_q + IDX_W'(1);
	assign hit_first  = scan_q - run_q[IDX_W-1:0];

	assign sts.chk_fail  = (kind_q == KIND_FREE) ? (below_base || beyond_end) : cnt_bad;
	assign sts.is_free   = (kind_q == KIND_FREE);
	assign sts.hit       = entry_free && (CMP_W'(run_q) + CMP_W'(1) == CMP_W'(count_q));
	assign sts.scan_last = (scan_q == IDX_W'(PAGES - 1));
	assign sts.free_stop = rdata_q[LAST_BIT] || entry_free || sts.scan_last;
	assign sts.mark_done = (scan_q == end_q);
	assign sts.out_free  = !m_valid_q || m_tready;

	always_comb begin
		we    = cmd.clr_step || cmd.scan_free || cmd.mark_step;
		waddr = scan_q;
		wdata = FLAGS_FREE;
		if (cmd.mark_step) begin
			wdata = (scan_q == end_q) ? FLAGS_LAST : FLAGS_USED;
		end
		raddr = cmd.check ? start_idx : scan_inc;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= s_tuser;
			count_q <= s_tdata[CNT_W-1:0];
			addr_q  <= s_tdata[CNT_W +: ADDR_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			run_q    <= '0;
			first_q  <= '0;
			end_q    <= '0;
			status_q <= ST_OK;
		end else begin
			if (cmd.check) begin
				scan_q <= start_idx;
				run_q  <= '0;
				if (!sts.chk_fail) begin
					status_q <= ST_OK;
				end else if (kind_q == KIND_FREE) begin
					status_q <= ST_RANGE;
				end else begin
					status_q <= ST_NOFIT;
				end
			end else if (cmd.scan_alloc) begin
				if (sts.hit) begin
					scan_q  <= hit_first;
					first_q <= hit_first;
					end_q   <= scan_q;
				end else begin
					scan_q <= scan_inc;
					run_q  <= entry_free ? run_q + RUN_W'(1) : '0;
					if (sts.scan_last) begin
						status_q <= ST_NOFIT;
					end
				end
			end else if (cmd.clr_step || cmd.scan_free || cmd.mark_step) begin
				scan_q <= scan_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_status_q <= status_q;
			if (status_q == ST_OK && kind_q == KIND_ALLOC) begin
				m_addr_q <= base_q + (ADDR_W'(first_q) << PAGE_SHIFT);
			end else begin
				m_addr_q <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, m_addr_q, m_status_q};

	a_mark_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_step |-> (first_q <= scan_q) && (scan_q <= end_q))
		else $error("mark pointer left the found run");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_alloc |-> (RUN_W'(scan_q) >= run_q))
		else $error("free run longer than pages scanned");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (m_status_q == ST_OK) || (m_addr_q == '0))
		else $error("failed item carries an address");

	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_valid_q || m_tready))
		else $error("result loaded over an untaken result");

endmodule

FILE: sv/first_fit_page_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator_top: first-fit contiguous page allocator
// Channel  | dir | signals                      | contents
// s_axis   | in  | s_tvalid s_tready s_tdata    | tdata: page_count, address
//          |     | s_tuser                      | tuser: kind
// m_axis   | out | m_tvalid m_tready m_tdata    | tdata: status, result_address
// cfg      | in  | cfg_valid cfg_ready cfg_data | base_address
//
// After reset a clearing pass zeroes the page table; no item is accepted
// until it ends, config writes are always taken.
// Allocate: check, scan up to the end of the first fitting run, then mark
// the run and give the result; free: check, clear entries, result. One table
// entry is read per cycle from the single-read-port flag memory.
// One item is in flight at a time; a finished result waits in the output
// register while the next item runs, and a stalled m_tready holds that item
// in its result phase until the register frees.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ffpa_pkg::ADDR_W-1:0] cfg_data,   // base_address
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [ffpa_pkg::IN_W-1:0]   s_tdata,    // page_count[10:0], address[58:11]
	input  logic                        s_tuser,    // kind
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ffpa_pkg::OUT_W-1:0]  m_tdata     // status[1:0], result_address[49:2]
);
	import ffpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ffpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the first-fit page allocator
// A shadow page table predicts the status and address of every request. It
// runs directed corner cases and then random alloc/free traffic over several
// base addresses, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import ffpa_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int IN_PAD      = IN_W - CNT_W - ADDR_W;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [ADDR_W-1:0] addr;
	} page_result_t;

	class page_table_tracker;
		logic [1:0]        flags [PAGES];
		logic [ADDR_W-1:0] base;
		page_result_t      pending_results [$];
		int                errors;

		function new();
			foreach (flags[i]) flags[i] = FLAGS_FREE;
			base   = '0;
			errors = 0;
		endfunction

		function void set_base(logic [ADDR_W-1:0] value);
			base = value;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// first used page at or after from (wrapping); optionally moved back to
		// the head of its allocation
		function int used_page(int from, bit head);
			int i;
			int k;
			for (k = 0; k < PAGES; k++) begin
				i = (from + k) % PAGES;
				if (flags[i] != FLAGS_FREE) begin
					if (head)
						while (i > 0 && flags[i-1] == FLAGS_USED) i--;
					return i;
				end
			end
			return -1;
		endfunction

		function void take_request(logic kind, logic [CNT_W-1:0] count,
				logic [ADDR_W-1:0] addr);
			page_result_t      r;
			int                run;
			int                first;
			int                i;
			int                k;
			logic [ADDR_W-1:0] offs;
			logic [ADDR_W-1:0] step;
			bit                stop;
			r.status = ST_OK;
			r.addr   = '0;
			if (kind == KIND_ALLOC) begin
				r.status = ST_NOFIT;
				run = 0;
				if (count != 0 && count <= PAGES) begin
					for (i = 0; i < PAGES; i++) begin
						if (flags[i] != FLAGS_FREE) begin
							run = 0;
						end else begin
							run++;
							if (run == int'(count)) begin
								first = i + 1 - run;
								for (k = first; k < i; k++) flags[k] = FLAGS_USED;
								flags[i] = FLAGS_LAST;
								step     = ADDR_W'(first);
								step     = step * PAGE_BYTES;
								r.status = ST_OK;
								r.addr   = base + step;
								break;
							end
						end
					end
				end
			end else if (addr < base) begin
				r.status = ST_RANGE;
			end else begin
				offs = (addr - base) / PAGE_BYTES;
				if (offs >= PAGES) begin
					r.status = ST_RANGE;
				end else begin
					for (i = int'(offs); i < PAGES; i++) begin
						stop     = flags[i][LAST_BIT] || flags[i] == FLAGS_FREE;
						flags[i] = FLAGS_FREE;
						if (stop)
							break;
					end
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_response(logic [OUT_W-1:0] word);
			page_result_t      want;
			logic [ST_W-1:0]   st;
			logic [ADDR_W-1:0] ad;
			st = word[ST_W-1:0];
			ad = word[ST_W +: ADDR_W];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected item, status %0d address %h", $time, st, ad);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (st !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, st);
				errors++;
			end
			if (ad !== want.addr) begin
				$display("%0t: address expected %h actual %h", $time, want.addr, ad);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ADDR_W-1:0] cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata   = '0;    // page_count, address
	logic              s_tuser   = 1'b0;  // kind
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_W-1:0]  m_tdata;           // status, result_address
	bit                quiet     = 1'b0;

	page_table_tracker pages = new();

	first_fit_page_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_top failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pages.check_response(m_tdata);
		m_tready <= quiet || $urandom_range(0, 99) >= 16;
	end

	function automatic logic [ADDR_W-1:0] rnd48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] page_addr(int idx, int off);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(idx);
		return pages.base + a * PAGE_BYTES + ADDR_W'(off);
	endfunction

	function automatic logic [CNT_W-1:0] alloc_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return CNT_W'($urandom_range(1, 8));
		if (r < 90) return CNT_W'($urandom_range(9, 64));
		if (r < 96) return CNT_W'($urandom_range(65, PAGES));
		if (r < 98) return '0;
		return CNT_W'($urandom_range(PAGES + 1, 2047));
	endfunction

	task automatic send_item(input logic kind, input logic [CNT_W-1:0] count,
			input logic [ADDR_W-1:0] addr);
		logic [IN_W-1:0] word;
		word = {{IN_PAD{1'b0}}, addr, count};
		while (!quiet && $urandom_range(0, 99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pages.take_request(kind, count, addr);
	endtask

	task automatic drain();
		while (pages.pending() != 0) @(posedge clk);
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		pages.set_base(value);
	endtask

	task automatic run_random(input int n, input int calm_from, input int calm_to);
		int                i;
		int                r;
		int                pg;
		logic              kind;
		logic [CNT_W-1:0]  cnt;
		logic [ADDR_W-1:0] adr;
		for (i = 0; i < n; i++) begin
			quiet = (i >= calm_from && i < calm_to);
			kind  = KIND_ALLOC;
			cnt   = CNT_W'($urandom_range(0, 2047));
			adr   = rnd48();
			r     = $urandom_range(0, 99);
			if (r < 45) begin
				cnt = alloc_size();
			end else if (r < 85) begin
				kind = KIND_FREE;
				pg   = pages.used_page($urandom_range(0, PAGES - 1),
					$urandom_range(0, 99) < 70);
				if (pg < 0)
					pg = $urandom_range(0, PAGES - 1);
				adr = page_addr(pg, $urandom_range(0, PAGE_BYTES - 1));
			end else if (r < 90) begin
				kind = KIND_FREE;
				adr  = page_addr($urandom_range(0, PAGES - 1),
					$urandom_range(0, PAGE_BYTES - 1));
			end else if (r < 95) begin
				kind = KIND_FREE;
				if (pages.base != 0 && $urandom_range(0, 1) == 1)
					adr = rnd48() % pages.base;
				else
					adr = page_addr(PAGES + $urandom_range(0, PAGES),
						$urandom_range(0, PAGE_BYTES - 1));
			end else begin
				kind = $urandom_range(0, 1) == 1 ? KIND_FREE : KIND_ALLOC;
			end
			send_item(kind, cnt, adr);
		end
		s_tvalid <= 1'b0;
		quiet = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, base 0
		write_base('0);
		send_item(KIND_ALLOC, 11'd0, '0);
		send_item(KIND_ALLOC, 11'd1025, '0);
		send_item(KIND_ALLOC, 11'd2047, '0);
		send_item(KIND_ALLOC, 11'd1, '0);
		send_item(KIND_ALLOC, 11'd3, '0);
		send_item(KIND_FREE, 11'd0, page_addr(2, 17));          // middle of a run
		send_item(KIND_FREE, 11'd0, page_addr(10, 0));          // page already free
		send_item(KIND_FREE, 11'd0, page_addr(PAGES, 0));
		send_item(KIND_FREE, 11'd0, '1);
		send_item(KIND_ALLOC, 11'd1, '0);
		send_item(KIND_FREE, 11'd0, page_addr(1, 0));
		send_item(KIND_FREE, 11'd0, page_addr(0, 0));
		send_item(KIND_ALLOC, 11'd1024, '0);
		send_item(KIND_ALLOC, 11'd1, '0);                       // table full
		send_item(KIND_FREE, 11'd0, page_addr(PAGES - 1, PAGE_BYTES - 1));
		send_item(KIND_ALLOC, 11'd1, '0);
		send_item(KIND_FREE, 11'd0, page_addr(0, 0));           // clears to table end
		send_item(KIND_ALLOC, 11'd2, '1);
		send_item(KIND_FREE, 11'd2047, page_addr(0, 0));
		s_tvalid <= 1'b0;

		// directed, top base: result addresses wrap
		write_base('1);
		send_item(KIND_FREE, 11'd0, '0);
		send_item(KIND_ALLOC, 11'd1, '0);
		send_item(KIND_ALLOC, 11'd2, '0);
		send_item(KIND_FREE, 11'd0, '1);
		send_item(KIND_FREE, 11'd0, 48'h0000_0000_0FFF);
		s_tvalid <= 1'b0;

		write_base(48'h0000_1234_5000);
		run_random(145, 0, 0);
		write_base(rnd48());
		run_random(145, 20, 100);
		write_base(48'hFFFF_FFF0_0000);
		run_random(145, 0, 0);
		write_base('0);
		run_random(145, 0, 0);

		drain();
		repeat (2 * PAGES + 16) @(posedge clk);
		if (pages.errors == 0 && pages.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
